// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared widths, register codes and the queued item type for the
// face-to-patch range search core.
// ----------------------------------------------------------------------------
package fpr_pkg;

	localparam int FACE_W      = 31;
	localparam int SLOT_W      = 6;
	localparam int PIDX_W      = 7;
	localparam int PCNT_W      = 7;
	localparam int REG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W      = 2;

	localparam logic signed [PIDX_W-1:0] NOT_FOUND_IDX = -7'sd1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_INTERNAL_FACES = 2'd0,
		REG_TOTAL_FACES    = 2'd1,
		REG_PATCH_COUNT    = 2'd2
	} cfg_reg_t;

	// one classified beat waiting for the search engine
	typedef struct packed {
		logic              is_query;
		logic              slot_ok;
		logic              reject;
		logic [SLOT_W-1:0] slot;
		logic [FACE_W-1:0] start;
		logic [FACE_W-1:0] size;
		logic [FACE_W-1:0] face;
	} item_t;

endpackage

// File: rtl/fpr_channels.sv
// ----------------------------------------------------------------------------
// fpr channels
// Valid/ready channel bundles for request beats and result beats.
// ----------------------------------------------------------------------------
interface fpr_req_if import fpr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [SLOT_W-1:0] entry_index;
	logic [FACE_W-1:0] entry_start;
	logic [FACE_W-1:0] entry_size;
	logic [FACE_W-1:0] face_index;

	modport source (output valid, action, entry_index, entry_start, entry_size,
		face_index, input ready);
	modport sink (input valid, action, entry_index, entry_start, entry_size,
		face_index, output ready);
endinterface

interface fpr_rsp_if import fpr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [PIDX_W-1:0] patch_index;
	logic [FACE_W-1:0]        local_face;

	modport source (output valid, found, patch_index, local_face, input ready);
	modport sink (input valid, found, patch_index, local_face, output ready);
endinterface

// File: rtl/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpr_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/fpr_front.sv
// ----------------------------------------------------------------------------
// fpr_front
// Accepts request beats, classifies them (load or query, slot range,
// face bounds) and holds them in a two-entry queue for the search engine.
// ----------------------------------------------------------------------------
module fpr_front import fpr_pkg::*; #(
	parameter int PATCH_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	fpr_req_if.sink           req,
	input  logic [FACE_W-1:0] internal_faces,
	input  logic [FACE_W-1:0] total_faces,
	input  logic              cnt_zero,
	output logic              q_valid,
	output item_t             q_item,
	input  logic              q_pop
);

	item_t             entry_q [QUEUE_DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             cls;
	logic              push;

	assign req.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = entry_q[rd_ptr_q];

	always_comb begin
		cls.is_query = req.action;
		cls.slot_ok  = (32'(req.entry_index) < 32'(PATCH_DEPTH));
		cls.reject   = (req.face_index < internal_faces) ||
			(req.face_index >= total_faces) || cnt_zero;
		cls.slot     = req.entry_index;
		cls.start    = req.entry_start;
		cls.size     = req.entry_size;
		cls.face     = req.face_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// File: rtl/fpr_back.sv
// ----------------------------------------------------------------------------
// fpr_back
// Search engine: writes table entries for loads and runs a binary search,
// one table probe per cycle, for queries. Results go to an output register.
// ----------------------------------------------------------------------------
module fpr_back import fpr_pkg::*; #(
	parameter int PATCH_DEPTH = 64,
	localparam int CW = $clog2(PATCH_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] cnt_sat,
	input  logic          q_valid,
	input  item_t         q_item,
	output logic          q_pop,
	fpr_rsp_if.source     rsp
);

	localparam int AW = (PATCH_DEPTH > 1) ? $clog2(PATCH_DEPTH) : 1;
	localparam int DW = 2 * FACE_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            lo_q;
	logic [CW-1:0]            hp_q;
	logic [CW-1:0]            mid_q;
	logic [FACE_W-1:0]        face_q;
	logic                     res_found_q;
	logic signed [PIDX_W-1:0] res_idx_q;
	logic [FACE_W-1:0]        res_local_q;
	logic                     out_valid_q;
	logic                     out_found_q;
	logic signed [PIDX_W-1:0] out_idx_q;
	logic [FACE_W-1:0]        out_local_q;

	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [DW-1:0]     ram_rdata;
	logic [FACE_W-1:0] ps;
	logic [FACE_W-1:0] sz;
	logic [FACE_W:0]   pend;
	logic              go_left;
	logic              go_right;
	logic              hit;
	logic [CW-1:0]     lo_n;
	logic [CW-1:0]     hp_n;
	logic [CW-1:0]     mid_n;
	logic [CW-1:0]     mid0;
	logic              more;
	logic              out_free;

	assign q_pop    = q_valid && (state_q == ST_IDLE);
	assign ram_we   = q_pop && !q_item.is_query && q_item.slot_ok;
	assign out_free = !out_valid_q || rsp.ready;

	assign ps       = ram_rdata[DW-1:FACE_W];
	assign sz       = ram_rdata[FACE_W-1:0];
	assign pend     = {1'b0, ps} + {1'b0, sz};
	assign go_left  = (face_q < ps);
	assign go_right = !go_left && ({1'b0, face_q} >= pend);
	assign hit      = !go_left && !go_right;
	assign lo_n     = go_right ? (mid_q + 1'b1) : lo_q;
	assign hp_n     = go_left ? mid_q : hp_q;
	assign more     = (lo_n < hp_n);
	assign mid_n    = CW'(({1'b0, lo_n} + {1'b0, hp_n} - 1'b1) >> 1);
	assign mid0     = CW'(({1'b0, cnt_sat} - 1'b1) >> 1);
	assign ram_raddr = (state_q == ST_PROBE) ? AW'(mid_n) : AW'(mid0);

	fpr_ram #(
		.WIDTH (DW),
		.DEPTH (PATCH_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(q_item.slot)),
		.wdata ({q_item.start, q_item.size}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.patch_index = out_idx_q;
	assign rsp.local_face  = out_local_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lo_q        <= '0;
			hp_q        <= '0;
			mid_q       <= '0;
			face_q      <= '0;
			res_found_q <= 1'b0;
			res_idx_q   <= NOT_FOUND_IDX;
			res_local_q <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_idx_q   <= NOT_FOUND_IDX;
			out_local_q <= '0;
		end else begin
			if (out_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.is_query) begin
						face_q <= q_item.face;
						if (q_item.reject) begin
							res_found_q <= 1'b0;
							res_idx_q   <= NOT_FOUND_IDX;
							res_local_q <= q_item.face;
							state_q     <= ST_DONE;
						end else begin
							lo_q    <= '0;
							hp_q    <= cnt_sat;
							mid_q   <= mid0;
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (hit) begin
						res_found_q <= 1'b1;
						res_idx_q   <= PIDX_W'(mid_q);
						res_local_q <= face_q - ps;
						state_q     <= ST_DONE;
					end else if (!more) begin
						res_found_q <= 1'b0;
						res_idx_q   <= NOT_FOUND_IDX;
						res_local_q <= face_q;
						state_q     <= ST_DONE;
					end else begin
						lo_q  <= lo_n;
						hp_q  <= hp_n;
						mid_q <= mid_n;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_idx_q   <= res_idx_q;
						out_local_q <= res_local_q;
						state_q     <= ST_IDLE;
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/face_to_patch_range_search_core.sv
// ----------------------------------------------------------------------------
// face_to_patch_range_search_core
// Locates the boundary patch holding a global face index by binary search
// over a loaded table of patch ranges.
// ----------------------------------------------------------------------------
// load beat: written to the table as it leaves the queue
// query beat: k table probes, k in 1..ceil(log2(count+1)), 7 at 64 entries;
// a rejected face takes no probes and goes straight to the result stage
// rate is set by the single table read port: one probe per cycle
// reset clears control and configuration; table contents stay undefined
module face_to_patch_range_search_core import fpr_pkg::*; #(
	parameter int PATCH_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fpr_req_if.sink              req,
	fpr_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [FACE_W-1:0]    cfg_data
);

	localparam int CW = $clog2(PATCH_DEPTH + 1);

	logic [FACE_W-1:0] internal_faces_q;
	logic [FACE_W-1:0] total_faces_q;
	logic [PCNT_W-1:0] patch_count_q;
	logic [CW-1:0]     cnt_sat;
	logic              q_valid;
	logic              q_pop;
	item_t             q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			internal_faces_q <= '0;
			total_faces_q    <= '0;
			patch_count_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INTERNAL_FACES: internal_faces_q <= cfg_data;
				REG_TOTAL_FACES:    total_faces_q    <= cfg_data;
				REG_PATCH_COUNT:    patch_count_q    <= cfg_data[PCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cnt_sat = (32'(patch_count_q) > 32'(PATCH_DEPTH)) ?
		CW'(PATCH_DEPTH) : CW'(patch_count_q);

	fpr_front #(
		.PATCH_DEPTH (PATCH_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.internal_faces (internal_faces_q),
		.total_faces    (total_faces_q),
		.cnt_zero       (cnt_sat == '0),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	fpr_back #(
		.PATCH_DEPTH (PATCH_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cnt_sat (cnt_sat),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

	// engine never pops an empty queue
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// a miss always reports the not-found patch code
	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.patch_index == NOT_FOUND_IDX))
		else $error("miss without not-found code");

	// a rejected query goes straight to the result stage, no probes
	a_reject_passes_face: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.is_query && q_item.reject) |=> !q_pop)
		else $error("rejected query not finished at once");

endmodule

// File: tb/sv/face_to_patch_range_search_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// face_to_patch_range_search_core_tb
// Self-checking testbench for the face-to-patch range search core. Patch
// tables are loaded in sorted and scrambled layouts, the face window and
// searched entry count are moved through their extremes, and every query
// result is compared field by field with a local binary search predictor.
// Both channels idle at random, with one quiet stretch.
// ----------------------------------------------------------------------------
module face_to_patch_range_search_core_tb import fpr_pkg::*; ();

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;
	localparam int   TABLE_DEPTH = 64;
	localparam int   SETTLE_CYCLES = 16;
	localparam logic [FACE_W-1:0] FACE_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic                     found;
		logic signed [PIDX_W-1:0] patch_index;
		logic [FACE_W-1:0]        local_face;
	} lookup_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [FACE_W-1:0]    cfg_data;

	fpr_req_if req_ch ();
	fpr_rsp_if rsp_ch ();

	face_to_patch_range_search_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the block state
	logic [FACE_W-1:0] patch_start [TABLE_DEPTH];
	logic [FACE_W-1:0] patch_size [TABLE_DEPTH];
	logic [FACE_W-1:0] internal_faces;
	logic [FACE_W-1:0] total_faces;
	logic [PCNT_W-1:0] searched_count;

	lookup_t pending_lookups [$];

	bit idle_on;
	bit stall_on;
	int error_count;
	int load_count;
	int query_count;
	int hit_count;
	int reg_write_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk)
		rsp_ch.ready <= !(stall_on && $urandom_range(0, 99) < 34);

	initial begin
		#(5_000_000);
		$display("face_to_patch_range_search_core_tb: errors");
		$finish;
	end

	function automatic lookup_t locate_face(input logic [FACE_W-1:0] face);
		lookup_t r;
		int lo;
		int hi;
		int mid;
		longint ps;
		longint pe;
		r.found = 1'b0;
		r.patch_index = NOT_FOUND_IDX;
		r.local_face = face;
		if (face < internal_faces || face >= total_faces)
			return r;
		lo = 0;
		hi = (searched_count > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(searched_count) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			ps = longint'(patch_start[mid]);
			pe = ps + longint'(patch_size[mid]) - 1;
			if (longint'(face) < ps)
				hi = mid - 1;
			else if (longint'(face) > pe)
				lo = mid + 1;
			else begin
				r.found = 1'b1;
				r.patch_index = PIDX_W'(mid);
				r.local_face = face - patch_start[mid];
				return r;
			end
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_lookups.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result beat: found=%0b patch=%0d local=%0d",
						rsp_ch.found, rsp_ch.patch_index, rsp_ch.local_face);
			end else begin
				want = pending_lookups.pop_front();
				if (rsp_ch.found !== want.found ||
						rsp_ch.patch_index !== want.patch_index ||
						rsp_ch.local_face !== want.local_face) begin
					error_count++;
					if (error_count <= 10)
						$display({"mismatch: expected found=%0b patch=%0d local=%0d,",
							" got found=%0b patch=%0d local=%0d"},
							want.found, want.patch_index, want.local_face,
							rsp_ch.found, rsp_ch.patch_index, rsp_ch.local_face);
				end
				if (want.found)
					hit_count++;
			end
		end
	end

	task automatic send_beat(input logic act, input logic [SLOT_W-1:0] slot,
			input logic [FACE_W-1:0] start, input logic [FACE_W-1:0] size,
			input logic [FACE_W-1:0] face);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 34) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.action      = act;
		req_ch.entry_index = slot;
		req_ch.entry_start = start;
		req_ch.entry_size  = size;
		req_ch.face_index  = face;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (act == ACT_LOAD) begin
			patch_start[slot] = start;
			patch_size[slot] = size;
			load_count++;
		end else begin
			pending_lookups.push_back(locate_face(face));
			query_count++;
		end
	endtask

	task automatic load_entry(input int slot, input logic [FACE_W-1:0] start,
			input logic [FACE_W-1:0] size);
		send_beat(ACT_LOAD, SLOT_W'(slot), start, size, FACE_W'($urandom()));
	endtask

	task automatic query_face(input logic [FACE_W-1:0] face);
		send_beat(ACT_QUERY, SLOT_W'($urandom()), FACE_W'($urandom()), FACE_W'($urandom()),
			face);
	endtask

	task automatic wait_results(input int settle);
		int guard;
		@(negedge clk);
		req_ch.valid = 1'b0;
		guard = 0;
		while (pending_lookups.size() != 0 && guard < 4000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_lookups.size() != 0) begin
			error_count += pending_lookups.size();
			$display("%0d result beats never arrived", pending_lookups.size());
			pending_lookups.delete();
		end
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [FACE_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = value;
		case (r)
			REG_INTERNAL_FACES: internal_faces = value;
			REG_TOTAL_FACES:    total_faces = value;
			REG_PATCH_COUNT:    searched_count = value[PCNT_W-1:0];
			default: ;
		endcase
		reg_write_count++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_window(input logic [FACE_W-1:0] lo_face, input logic [FACE_W-1:0] hi_face,
			input logic [FACE_W-1:0] cnt);
		wait_results(SETTLE_CYCLES);
		write_reg(REG_INTERNAL_FACES, lo_face);
		write_reg(REG_TOTAL_FACES, hi_face);
		write_reg(REG_PATCH_COUNT, cnt);
	endtask

	// contiguous sorted layout, some patches empty
	task automatic fill_sorted(input logic [FACE_W-1:0] base, input int unsigned max_size,
			output logic [FACE_W-1:0] end_face);
		longint cursor;
		int unsigned sz;
		cursor = longint'(base);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sz = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(max_size, 1);
			load_entry(i, FACE_W'(cursor), FACE_W'(sz));
			cursor += sz;
		end
		end_face = FACE_W'(cursor);
	endtask

	function automatic logic [FACE_W-1:0] pick_face();
		int unsigned s;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			s = $urandom_range(TABLE_DEPTH - 1, 0);
			if (patch_size[s] == 0)
				return patch_start[s];
			return patch_start[s] + FACE_W'($urandom_range(patch_size[s] - 1, 0));
		end else if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return internal_faces - 1'b1;
				1: return internal_faces;
				2: return total_faces - 1'b1;
				default: return total_faces;
			endcase
		end
		return FACE_W'($urandom());
	endfunction

	task automatic test_reset_state();
		query_face('0);
		query_face(FACE_MAX);
		query_face(FACE_W'($urandom()));
		set_window('0, '0, '0);
	endtask

	task automatic test_directed_lookups();
		for (int i = 0; i < TABLE_DEPTH - 1; i++)
			load_entry(i, FACE_W'(1000 + 16 * i), (i == 5) ? '0 : FACE_W'(16));
		load_entry(TABLE_DEPTH - 1, 31'h7FFF_FF00, FACE_MAX);
		set_window(FACE_W'(1000), FACE_MAX, FACE_W'(64));
		query_face(FACE_W'(999));
		query_face(FACE_W'(1000));
		query_face(FACE_W'(1015));
		query_face(FACE_W'(1016));
		query_face(FACE_W'(1080));   // empty patch
		query_face(FACE_W'(2007));
		query_face(FACE_W'(2008));
		query_face(31'h7FFF_FF00);
		query_face(31'h7FFF_FFFE);
		query_face(FACE_MAX);
		query_face('0);
		set_window(FACE_W'(1000), FACE_MAX, FACE_W'(1));
		query_face(FACE_W'(1000));
		query_face(FACE_W'(1016));
		set_window(FACE_W'(1000), FACE_MAX, FACE_W'(127));   // saturates
		query_face(31'h7FFF_FF10);
		set_window(FACE_W'(1000), FACE_MAX, '0);
		query_face(FACE_W'(1000));
		set_window(FACE_MAX, FACE_MAX, FACE_W'(64));
		query_face(FACE_MAX);
	endtask

	task automatic test_unsorted_table();
		load_entry(0, FACE_W'(5000), FACE_W'(10));
		load_entry(1, FACE_W'(1000), FACE_W'(10));
		set_window('0, FACE_W'(10000), FACE_W'(2));
		query_face(FACE_W'(1005));
		query_face(FACE_W'(5005));
		query_face(FACE_W'(1000));
	endtask

	task automatic test_random_traffic();
		logic [FACE_W-1:0] base;
		logic [FACE_W-1:0] end_face;
		logic [FACE_W-1:0] lo_face;
		logic [FACE_W-1:0] hi_face;
		logic [FACE_W-1:0] cnt;
		int unsigned max_size;
		for (int p = 0; p < 8; p++) begin
			idle_on = (p != 3);
			stall_on = (p != 3);
			case (p)
				0: begin base = '0; max_size = 4; end
				1: begin base = FACE_W'($urandom_range(1_000_000, 0)); max_size = 100; end
				2: begin base = FACE_MAX - 31'd4200; max_size = 64; end
				default: begin
					base = FACE_W'($urandom_range(1_000_000_000, 0));
					max_size = $urandom_range(1_000_000, 1);
				end
			endcase
			fill_sorted(base, max_size, end_face);
			lo_face = (p % 2) ? base : base + FACE_W'($urandom_range(3, 0));
			hi_face = (p == 2) ? FACE_MAX : end_face + FACE_W'($urandom_range(5, 0));
			case (p)
				0: cnt = FACE_W'(64);
				4: cnt = '0;
				5: cnt = FACE_W'(127);
				default: cnt = FACE_W'($urandom_range(64, 1));
			endcase
			set_window(lo_face, hi_face, cnt);
			for (int k = 0; k < 50; k++) begin
				if (p == 2 && k == 30)
					wait_results(0);
				if ($urandom_range(0, 99) < 15)
					load_entry($urandom_range(TABLE_DEPTH - 1, 0), FACE_W'($urandom()),
						FACE_W'($urandom()));
				else
					query_face(pick_face());
			end
		end
		idle_on = 1'b1;
		stall_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_LOAD;
		req_ch.entry_index = '0;
		req_ch.entry_start = '0;
		req_ch.entry_size = '0;
		req_ch.face_index = '0;
		rsp_ch.ready = 1'b0;
		internal_faces = '0;
		total_faces = '0;
		searched_count = '0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		error_count = 0;
		load_count = 0;
		query_count = 0;
		hit_count = 0;
		reg_write_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_lookups();
		test_unsorted_table();
		test_random_traffic();
		wait_results(SETTLE_CYCLES);

		$display("covered %0d table loads and %0d face lookups (%0d hits)",
			load_count, query_count, hit_count);
		$display("over %0d register writes, sorted and scrambled tables", reg_write_count);
		if (error_count == 0)
			$display("face_to_patch_range_search_core_tb: clean");
		else
			$display("face_to_patch_range_search_core_tb: errors");
		$finish;
	end

endmodule
